FILE: rtl/core/video_object_layer_header_parser_unit_assert.svh
`ifndef VIDEO_OBJECT_LAYER_HEADER_PARSER_UNIT_ASSERT_SVH
`define VIDEO_OBJECT_LAYER_HEADER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define VOL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vol header parser: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define VOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vol header parser: assertion failed");

`endif

FILE: rtl/core/vol_pkg.sv
package vol_pkg;

	// one queued input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} word_t;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic  valid;
		word_t word;
	} q_head_t;

	typedef struct packed {
		logic        random_access;
		logic [7:0]  object_kind;
		logic [7:0]  aspect_num;
		logic [7:0]  aspect_den;
		logic [1:0]  shape_code;
		logic [15:0] tick_rate;
		logic [4:0]  increment_bits;
		logic [15:0] fixed_increment;
		logic [12:0] frame_width;
		logic [12:0] frame_height;
	} fields_t;

	localparam logic [3:0] ASPECT_ESCAPE = 4'hF;
	localparam logic [3:0] ASPECT_CODES  = 4'd6;
	localparam logic [1:0] SHAPE_RECT    = 2'd0;
	localparam logic [1:0] SHAPE_GRAY    = 2'd3;
	localparam logic [3:0] VERSION_ONE   = 4'd1;
	localparam logic       STATUS_OK     = 1'b0;
	localparam logic       STATUS_TRUNC  = 1'b1;

	// bit length of rate-1, at least one
	function automatic logic [4:0] incr_bits(input logic [15:0] rate);
		logic [15:0] c;
		logic [4:0]  n;
		c = rate - 16'd1;
		n = 5'd1;
		if (rate > 16'd1) begin
			for (int k = 0; k < 16; k++) begin
				if (c[k])
					n = 5'(k + 1);
			end
		end
		return n;
	endfunction

	function automatic logic [7:0] aspect_num(input logic [2:0] code);
		logic [7:0] v;
		case (code)
			3'd1:    v = 8'd1;
			3'd2:    v = 8'd12;
			3'd3:    v = 8'd10;
			3'd4:    v = 8'd16;
			3'd5:    v = 8'd40;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] aspect_den(input logic [2:0] code);
		logic [7:0] v;
		case (code)
			3'd1:                   v = 8'd1;
			3'd2, 3'd3, 3'd4:       v = 8'd11;
			3'd5:                   v = 8'd33;
			default:                v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/vol_byte_if.sv
interface vol_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source(output valid, data_byte, first_byte, last_byte, input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

FILE: rtl/core/vol_result_if.sv
interface vol_result_if;
	logic        valid;
	logic        ready;
	logic        random_access;
	logic [7:0]  object_kind;
	logic [7:0]  aspect_num;
	logic [7:0]  aspect_den;
	logic [1:0]  shape_code;
	logic [15:0] tick_rate;
	logic [4:0]  increment_bits;
	logic [15:0] fixed_increment;
	logic [12:0] frame_width;
	logic [12:0] frame_height;
	logic        parse_status;

	modport source(output valid, random_access, object_kind, aspect_num, aspect_den,
		shape_code, tick_rate, increment_bits, fixed_increment, frame_width,
		frame_height, parse_status, input ready);
	modport sink(input valid, random_access, object_kind, aspect_num, aspect_den,
		shape_code, tick_rate, increment_bits, fixed_increment, frame_width,
		frame_height, parse_status, output ready);
endinterface

FILE: rtl/core/vol_front.sv
module vol_front (
	input  logic             clk,
	input  logic             arst_n,
	vol_byte_if.sink         stream,
	input  logic             pop,
	output vol_pkg::q_head_t head
);

	vol_pkg::word_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign stream.ready = (cnt_q != 2'd2);
	assign push         = stream.valid && stream.ready;

	assign head.valid = (cnt_q != 2'd0);
	assign head.word  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data_byte: stream.data_byte, first_byte: stream.first_byte,
				last_byte: stream.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/vol_back.sv
module vol_back (
	input  logic             clk,
	input  logic             arst_n,
	input  vol_pkg::q_head_t head,
	output logic             pop,
	vol_result_if.source     result
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RAP    = 5'd1;
	localparam logic [4:0] S_OBJ    = 5'd2;
	localparam logic [4:0] S_IDF    = 5'd3;
	localparam logic [4:0] S_VERID  = 5'd4;
	localparam logic [4:0] S_PRIO   = 5'd5;
	localparam logic [4:0] S_PAR    = 5'd6;
	localparam logic [4:0] S_PARNUM = 5'd7;
	localparam logic [4:0] S_PARDEN = 5'd8;
	localparam logic [4:0] S_CTRL   = 5'd9;
	localparam logic [4:0] S_CTRL3  = 5'd10;
	localparam logic [4:0] S_VBVF   = 5'd11;
	localparam logic [4:0] S_VBV    = 5'd12;
	localparam logic [4:0] S_SHAPE  = 5'd13;
	localparam logic [4:0] S_SHEXT  = 5'd14;
	localparam logic [4:0] S_MARK1  = 5'd15;
	localparam logic [4:0] S_RATE   = 5'd16;
	localparam logic [4:0] S_MARK2  = 5'd17;
	localparam logic [4:0] S_FIXF   = 5'd18;
	localparam logic [4:0] S_FIXINC = 5'd19;
	localparam logic [4:0] S_MARKW  = 5'd20;
	localparam logic [4:0] S_WIDTH  = 5'd21;
	localparam logic [4:0] S_MARKH  = 5'd22;
	localparam logic [4:0] S_HEIGHT = 5'd23;
	localparam logic [4:0] S_DONE   = 5'd24;

	logic [4:0]       step_q;
	logic [6:0]       left_q;
	logic [15:0]      acc_q;
	logic [3:0]       ver_q;
	vol_pkg::fields_t fld_q;
	vol_pkg::fields_t res_q;
	logic             status_q;
	logic             out_valid_q;

	logic [4:0]       st;
	logic [6:0]       lf;
	logic [15:0]      ac;
	logic [3:0]       vr;
	vol_pkg::fields_t fd;
	logic [4:0]       ns;
	logic [6:0]       nl;
	logic             active;
	logic             emit;
	logic             trunc;
	vol_pkg::fields_t trunc_res;

	assign pop = head.valid && (!out_valid_q || result.ready);

	always_comb begin
		trunc_res                = '0;
		trunc_res.increment_bits = 5'd1;
	end

	// eight bit steps of the field sequencer per word
	always_comb begin
		st     = step_q;
		lf     = left_q;
		ac     = acc_q;
		vr     = ver_q;
		fd     = fld_q;
		ns     = S_IDLE;
		nl     = '0;
		emit   = 1'b0;
		trunc  = 1'b0;
		if (head.word.first_byte) begin
			st = S_RAP;
			lf = 7'd1;
			ac = '0;
			vr = '0;
			fd = '0;
		end
		active = (st != S_IDLE) && (st != S_DONE);
		if (active) begin
			for (int i = 7; i >= 0; i--) begin
				if (st != S_DONE) begin
					ac = {ac[14:0], head.word.data_byte[3'(i)]};
					if (lf != '0)
						lf = lf - 7'd1;
					if (lf == '0) begin
						ns = S_IDLE;
						nl = '0;
						unique case (st)
							S_RAP: begin
								fd.random_access = ac[0];
								ns = S_OBJ; nl = 7'd8;
							end
							S_OBJ: begin
								fd.object_kind = ac[7:0];
								ns = S_IDF; nl = 7'd1;
							end
							S_IDF: begin
								if (ac[0]) begin
									ns = S_VERID; nl = 7'd4;
								end else begin
									ns = S_PAR; nl = 7'd4;
								end
							end
							S_VERID: begin
								vr = ac[3:0];
								ns = S_PRIO; nl = 7'd3;
							end
							S_PRIO: begin
								ns = S_PAR; nl = 7'd4;
							end
							S_PAR: begin
								if (ac[3:0] == vol_pkg::ASPECT_ESCAPE) begin
									ns = S_PARNUM; nl = 7'd8;
								end else begin
									if (ac[3:0] < vol_pkg::ASPECT_CODES) begin
										fd.aspect_num = vol_pkg::aspect_num(ac[2:0]);
										fd.aspect_den = vol_pkg::aspect_den(ac[2:0]);
									end
									ns = S_CTRL; nl = 7'd1;
								end
							end
							S_PARNUM: begin
								fd.aspect_num = ac[7:0];
								ns = S_PARDEN; nl = 7'd8;
							end
							S_PARDEN: begin
								fd.aspect_den = ac[7:0];
								ns = S_CTRL; nl = 7'd1;
							end
							S_CTRL: begin
								if (ac[0]) begin
									ns = S_CTRL3; nl = 7'd3;
								end else begin
									ns = S_SHAPE; nl = 7'd2;
								end
							end
							S_CTRL3: begin
								ns = S_VBVF; nl = 7'd1;
							end
							S_VBVF: begin
								if (ac[0]) begin
									ns = S_VBV; nl = 7'd79;
								end else begin
									ns = S_SHAPE; nl = 7'd2;
								end
							end
							S_VBV: begin
								ns = S_SHAPE; nl = 7'd2;
							end
							S_SHAPE: begin
								fd.shape_code = ac[1:0];
								if (ac[1:0] == vol_pkg::SHAPE_GRAY && vr != vol_pkg::VERSION_ONE) begin
									ns = S_SHEXT; nl = 7'd4;
								end else begin
									ns = S_MARK1; nl = 7'd1;
								end
							end
							S_SHEXT: begin
								ns = S_MARK1; nl = 7'd1;
							end
							S_MARK1: begin
								ns = S_RATE; nl = 7'd16;
							end
							S_RATE: begin
								fd.tick_rate      = ac;
								fd.increment_bits = vol_pkg::incr_bits(ac);
								ns = S_MARK2; nl = 7'd1;
							end
							S_MARK2: begin
								ns = S_FIXF; nl = 7'd1;
							end
							S_FIXF: begin
								if (ac[0]) begin
									ns = S_FIXINC; nl = {2'b00, fd.increment_bits};
								end else if (fd.shape_code == vol_pkg::SHAPE_RECT) begin
									ns = S_MARKW; nl = 7'd1;
								end else begin
									ns = S_DONE; nl = '0;
								end
							end
							S_FIXINC: begin
								fd.fixed_increment = ac;
								if (fd.shape_code == vol_pkg::SHAPE_RECT) begin
									ns = S_MARKW; nl = 7'd1;
								end else begin
									ns = S_DONE; nl = '0;
								end
							end
							S_MARKW: begin
								ns = S_WIDTH; nl = 7'd13;
							end
							S_WIDTH: begin
								fd.frame_width = ac[12:0];
								ns = S_MARKH; nl = 7'd1;
							end
							S_MARKH: begin
								ns = S_HEIGHT; nl = 7'd13;
							end
							S_HEIGHT: begin
								fd.frame_height = ac[12:0];
								ns = S_DONE; nl = '0;
							end
							default: begin
								ns = S_IDLE; nl = '0;
							end
						endcase
						st = ns;
						lf = nl;
						ac = '0;
					end
				end
			end
			if (st == S_DONE) begin
				emit = 1'b1;
			end else if (head.word.last_byte) begin
				emit  = 1'b1;
				trunc = 1'b1;
				st    = S_IDLE;
				lf    = '0;
				ac    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_IDLE;
			left_q      <= '0;
			acc_q       <= '0;
			ver_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				step_q      <= st;
				left_q      <= lf;
				acc_q       <= ac;
				ver_q       <= vr;
				out_valid_q <= emit;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fld_q <= fd;
			if (emit) begin
				res_q    <= trunc ? trunc_res : fd;
				status_q <= trunc ? vol_pkg::STATUS_TRUNC : vol_pkg::STATUS_OK;
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.random_access   = res_q.random_access;
	assign result.object_kind     = res_q.object_kind;
	assign result.aspect_num      = res_q.aspect_num;
	assign result.aspect_den      = res_q.aspect_den;
	assign result.shape_code      = res_q.shape_code;
	assign result.tick_rate       = res_q.tick_rate;
	assign result.increment_bits  = res_q.increment_bits;
	assign result.fixed_increment = res_q.fixed_increment;
	assign result.frame_width     = res_q.frame_width;
	assign result.frame_height    = res_q.frame_height;
	assign result.parse_status    = status_q;

endmodule

FILE: rtl/core/video_object_layer_header_parser_unit.sv
// MPEG-4 video object layer header parser.
// stream: one header byte per word, bits read MSB first. first_byte restarts
//   the parse at this byte; last_byte marks the final byte, and a header not
//   finished by then gives a result with parse_status set.
// result: one word per header, at the byte holding its last bit (the rest of
//   that byte is dropped); bytes outside a header give nothing.
// Throughput: one byte per cycle while no result is held. A two-word queue at the
//   input feeds a sequencer that walks the eight bits of a byte through the
//   header's field steps at once, in combinational logic.
// Path: a header's last byte is written into the queue, and its result is
//   registered in the output register when that byte leaves the queue.
// Stall: a held result stays in the output register and the sequencer waits
//   until it is taken; the queue keeps taking bytes until both entries are
//   full.
// Reset: arst_n clears the queue and the output valid and puts the parser
//   idle; bytes are then ignored until one with first_byte.
module video_object_layer_header_parser_unit (
	input logic          clk,
	input logic          arst_n,
	vol_byte_if.sink     stream,
	vol_result_if.source result
);

	vol_pkg::q_head_t head;
	logic             pop;

	vol_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.pop    (pop),
		.head   (head)
	);

	vol_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

FILE: rtl/core/vol_checker.sv
`include "video_object_layer_header_parser_unit_assert.svh"

module vol_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        random_access,
	input logic [7:0]  object_kind,
	input logic [7:0]  aspect_num,
	input logic [7:0]  aspect_den,
	input logic [1:0]  shape_code,
	input logic [15:0] tick_rate,
	input logic [4:0]  increment_bits,
	input logic [15:0] fixed_increment,
	input logic [12:0] frame_width,
	input logic [12:0] frame_height,
	input logic        parse_status
);

	logic incr_ok;
	logic is_trunc;
	logic is_nonrect;
	logic trunc_zero;
	logic size_zero;

	assign incr_ok    = (increment_bits >= 5'd1) && (increment_bits <= 5'd16);
	assign is_trunc   = (parse_status == vol_pkg::STATUS_TRUNC);
	assign is_nonrect = (shape_code != vol_pkg::SHAPE_RECT);
	assign size_zero  = (frame_width == 13'd0) && (frame_height == 13'd0);
	assign trunc_zero = !random_access && object_kind == 8'd0 && aspect_num == 8'd0 &&
		aspect_den == 8'd0 && shape_code == vol_pkg::SHAPE_RECT && tick_rate == 16'd0 &&
		increment_bits == 5'd1 && fixed_increment == 16'd0 && size_zero;

	`VOL_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid && !out_ready, out_valid)
	`VOL_ASSERT_NOW(a_incr_range, clk, arst_n, out_valid, incr_ok)
	`VOL_ASSERT_NOW(a_trunc_clean, clk, arst_n, out_valid && is_trunc, trunc_zero)
	`VOL_ASSERT_NOW(a_nonrect_size, clk, arst_n, out_valid && is_nonrect, size_zero)

endmodule

bind video_object_layer_header_parser_unit vol_checker u_vol_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.random_access   (result.random_access),
	.object_kind     (result.object_kind),
	.aspect_num      (result.aspect_num),
	.aspect_den      (result.aspect_den),
	.shape_code      (result.shape_code),
	.tick_rate       (result.tick_rate),
	.increment_bits  (result.increment_bits),
	.fixed_increment (result.fixed_increment),
	.frame_width     (result.frame_width),
	.frame_height    (result.frame_height),
	.parse_status    (result.parse_status)
);
